// ----- rtl/rtt_pkg.sv -----
`default_nettype none

package rtt_pkg;

  // Operation codes carried in the request op field
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_NACK = 2'd2;
  localparam logic [1:0] OP_SCAN = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_ADDED      = 3'd0;
  localparam logic [2:0] KIND_FULL       = 3'd1;
  localparam logic [2:0] KIND_REMOVED    = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND  = 3'd3;
  localparam logic [2:0] KIND_RETRANSMIT = 3'd4;
  localparam logic [2:0] KIND_GAVE_UP    = 3'd5;
  localparam logic [2:0] KIND_SCAN_DONE  = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'd1;

  // Reset values of the configuration registers
  localparam logic [15:0] TIMEOUT_RST = 16'd2;
  localparam logic [7:0]  RETRY_RST   = 8'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] msg_id;
    logic [15:0] dest_handle;
    logic [31:0] now_time;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_id;
    logic [15:0] out_dest;
    logic        last;
  } rsp_item_t;

  // One table entry as held by a ring cell
  typedef struct packed {
    logic        valid;
    logic [31:0] msg_id;
    logic [15:0] dest;
    logic [31:0] sent_time;
    logic [7:0]  retries;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/rtt_cell.sv -----
`default_nettype none

module rtt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire rtt_pkg::entry_t d,
  output rtt_pkg::entry_t      q
);
  import rtt_pkg::*;

  logic   valid;
  entry_t data;

  // Valid bit is the only part cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  // Entry payload moves with the ring
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  always_comb begin
    q       = data;
    q.valid = valid;
  end

endmodule

`default_nettype wire

// ----- rtl/retransmit_timeout_table.sv -----
// Retransmission timer table.
// Request channel (req_valid/req_ready/req) takes one item: add, ack, nack
// or timeout scan. Response channel (rsp_valid/rsp_ready/rsp) returns the
// results of that item, the final one marked with last.
// Entries live in a ring of TABLE_DEPTH cells that rotates one place per
// cycle during a pass, unless a stalled scan result holds it, past a single
// head unit doing the id compare and the age check. Every item takes one
// full revolution before its final result is loaded. An add whose id is
// absent and that finds a free slot takes a second revolution to insert
// into the lowest free slot. The next item is taken as soon as the final
// result sits in the output register, while that result may still wait for
// the receiver.
// When the receiver stalls during a scan, the ring holds on the expired
// entry until the output register frees, so no result is lost.
// Reset (rst, synchronous) clears every entry's valid bit at once and sets
// timeout to 2 and retry_limit to 3. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce this.
`default_nettype none

module retransmit_timeout_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire rtt_pkg::req_item_t                 req,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output rtt_pkg::rsp_item_t                      rsp,
  input  wire logic                               cfg_we,
  input  wire logic [rtt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rtt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rtt_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PASS   = 4'b0010,
    S_INSERT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t      state;
  req_item_t   cmd;
  logic [IW-1:0] idx;
  logic [IW-1:0] free_idx;
  logic        found;
  logic        free_found;
  logic [15:0] nack_dest;
  logic [15:0] timeout;
  logic [7:0]  retry_limit;

  entry_t      ring [TABLE_DEPTH];
  entry_t      head;
  entry_t      head_new;
  entry_t      new_entry;
  logic        step;
  logic        match;
  logic        expired;
  logic        scan_hit;
  logic        under_limit;
  logic        can_emit;
  logic        rsp_load;
  logic [31:0] age;
  rsp_item_t   scan_item;
  rsp_item_t   final_item;
  rsp_item_t   rsp_next;

  // Ring of cells; the head cell feeds the tail through the head unit
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == TABLE_DEPTH - 1) begin : g_tail
      rtt_cell u_cell (.clk(clk), .rst(rst), .shift(step), .d(head_new), .q(ring[k]));
    end else begin : g_mid
      rtt_cell u_cell (.clk(clk), .rst(rst), .shift(step), .d(ring[k+1]), .q(ring[k]));
    end
  end

  assign head      = ring[0];
  assign req_ready = (state == S_IDLE);
  assign can_emit  = !rsp_valid || rsp_ready;

  // Head unit: compare and age check
  always_comb begin
    match       = head.valid && (head.msg_id == cmd.msg_id);
    age         = cmd.now_time - head.sent_time;
    expired     = head.valid && (age > {16'd0, timeout});
    under_limit = head.retries < retry_limit;
    scan_hit    = (cmd.op == OP_SCAN) && expired;
    new_entry   = '{valid: 1'b1, msg_id: cmd.msg_id, dest: cmd.dest_handle,
                    sent_time: cmd.now_time, retries: 8'd0};
  end

  // Step control and entry update at the head
  always_comb begin
    step     = 1'b0;
    head_new = head;
    unique case (state)
      S_PASS: begin
        step = !(scan_hit && !can_emit);
        unique case (cmd.op)
          OP_ADD: begin
            if (match) begin
              head_new = new_entry;
            end
          end
          OP_ACK: begin
            if (match) begin
              head_new.valid = 1'b0;
            end
          end
          OP_NACK: begin
            head_new = head;
          end
          OP_SCAN: begin
            if (expired) begin
              if (under_limit) begin
                head_new.sent_time = cmd.now_time;
                head_new.retries   = head.retries + 8'd1;
              end else begin
                head_new.valid = 1'b0;
              end
            end
          end
          default: head_new = head;
        endcase
      end
      S_INSERT: begin
        step = 1'b1;
        if (idx == free_idx) begin
          head_new = new_entry;
        end
      end
      default: step = 1'b0;
    endcase
  end

  // Result selection
  always_comb begin
    scan_item = '{kind: (under_limit ? KIND_RETRANSMIT : KIND_GAVE_UP),
                  out_id: head.msg_id, out_dest: head.dest, last: 1'b0};
    final_item = '{kind: KIND_SCAN_DONE, out_id: cmd.msg_id, out_dest: 16'd0,
                   last: 1'b1};
    unique case (cmd.op)
      OP_ADD:  final_item.kind = (found || free_found) ? KIND_ADDED : KIND_FULL;
      OP_ACK:  final_item.kind = found ? KIND_REMOVED : KIND_NOT_FOUND;
      OP_NACK: begin
        final_item.kind = found ? KIND_RETRANSMIT : KIND_NOT_FOUND;
        if (found) begin
          final_item.out_dest = nack_dest;
        end
      end
      OP_SCAN: final_item.out_id = 32'd0;
      default: final_item.kind = KIND_SCAN_DONE;
    endcase
    rsp_load = can_emit && (((state == S_PASS) && scan_hit) || (state == S_RESULT));
    rsp_next = (state == S_RESULT) ? final_item : scan_item;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state      <= S_PASS;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_PASS: begin
          if (step) begin
            if (match && (cmd.op != OP_SCAN)) begin
              found <= 1'b1;
            end
            if ((cmd.op == OP_ADD) && !head.valid && !free_found) begin
              free_found <= 1'b1;
            end
            if (idx == LAST_IDX) begin
              idx <= '0;
              if ((cmd.op == OP_ADD) && !found && !match
                  && (free_found || !head.valid)) begin
                state <= S_INSERT;
              end else begin
                state <= S_RESULT;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_INSERT: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_RESULT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RESULT: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item capture and search notes
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= req;
    end
    if ((state == S_PASS) && step) begin
      if (match) begin
        nack_dest <= head.dest;
      end
      if ((cmd.op == OP_ADD) && !head.valid && !free_found) begin
        free_idx <= idx;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout     <= TIMEOUT_RST;
      retry_limit <= RETRY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout     <= cfg_data;
        CFG_RETRY:   retry_limit <= cfg_data[7:0];
        default:     timeout     <= timeout;
      endcase
    end
  end

`ifndef SYNTH
  // Between items the ring is back in index order
  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (idx == '0))
    else $error("ring not aligned while idle");

  // Final result is loaded with last set and the block returns to idle
  a_final_load: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESULT) && can_emit) |=> ((state == S_IDLE) && rsp_valid && rsp.last))
    else $error("final result not delivered");

  // An expired entry blocked by the receiver holds the ring still
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PASS) && scan_hit && !can_emit) |=> $stable(idx))
    else $error("ring moved past an undelivered scan result");

  // Insert pass only for a new id with room in the table
  a_insert_cause: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> ((cmd.op == OP_ADD) && free_found && !found))
    else $error("insert pass without cause");
`endif

endmodule

`default_nettype wire

// ----- tb/rtt_result_checker.sv -----
`timescale 1ns / 1ps

module rtt_result_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_ready,
  input  rtt_pkg::req_item_t               req,
  input  logic                             rsp_valid,
  input  logic                             rsp_ready,
  input  rtt_pkg::rsp_item_t               rsp,
  input  logic                             cfg_we,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               mismatch_count,
  output int                               results_owed
);
  import rtt_pkg::*;

  // Shadow copy of the pending-message table and its settings
  logic        tbl_valid   [DEPTH];
  logic [31:0] tbl_id      [DEPTH];
  logic [15:0] tbl_dest    [DEPTH];
  logic [31:0] tbl_sent    [DEPTH];
  logic [7:0]  tbl_retries [DEPTH];
  logic [15:0] timeout_cfg;
  logic [7:0]  retry_cfg;

  // Results owed by the block, oldest first
  rsp_item_t expected_results[$];
  int        mismatches = 0;

  function automatic rsp_item_t result_of(logic [2:0] kind, logic [31:0] id,
                                          logic [15:0] dest, logic last_flag);
    rsp_item_t r;
    r.kind     = kind;
    r.out_id   = id;
    r.out_dest = dest;
    r.last     = last_flag;
    return r;
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  task automatic predict_request(input req_item_t r);
    int          hit;
    int          slot;
    logic [31:0] age;
    hit = -1;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_id[i] == r.msg_id) hit = i;
    end
    case (r.op)
      OP_ADD: begin
        // existing id is overwritten in place, otherwise lowest free index
        slot = hit;
        if (slot < 0) begin
          for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
          end
        end
        if (slot < 0) begin
          expected_results.push_back(result_of(KIND_FULL, r.msg_id, '0, 1'b1));
        end else begin
          tbl_valid[slot]   = 1'b1;
          tbl_id[slot]      = r.msg_id;
          tbl_dest[slot]    = r.dest_handle;
          tbl_sent[slot]    = r.now_time;
          tbl_retries[slot] = '0;
          expected_results.push_back(result_of(KIND_ADDED, r.msg_id, '0, 1'b1));
        end
      end
      OP_ACK: begin
        if (hit < 0) begin
          expected_results.push_back(result_of(KIND_NOT_FOUND, r.msg_id, '0, 1'b1));
        end else begin
          tbl_valid[hit] = 1'b0;
          expected_results.push_back(result_of(KIND_REMOVED, r.msg_id, '0, 1'b1));
        end
      end
      OP_NACK: begin
        if (hit < 0)
          expected_results.push_back(result_of(KIND_NOT_FOUND, r.msg_id, '0, 1'b1));
        else
          expected_results.push_back(result_of(KIND_RETRANSMIT, r.msg_id, tbl_dest[hit],
                                               1'b1));
      end
      default: begin
        // timeout scan in index order; age wraps modulo 2^32
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) begin
            age = r.now_time - tbl_sent[i];
            if (age > {16'd0, timeout_cfg}) begin
              if (tbl_retries[i] < retry_cfg) begin
                tbl_sent[i]    = r.now_time;
                tbl_retries[i] = tbl_retries[i] + 8'd1;
                expected_results.push_back(result_of(KIND_RETRANSMIT, tbl_id[i],
                                                     tbl_dest[i], 1'b0));
              end else begin
                tbl_valid[i] = 1'b0;
                expected_results.push_back(result_of(KIND_GAVE_UP, tbl_id[i],
                                                     tbl_dest[i], 1'b0));
              end
            end
          end
        end
        expected_results.push_back(result_of(KIND_SCAN_DONE, '0, '0, 1'b1));
      end
    endcase
  endtask

  // Results are checked before the request of the same edge is predicted
  always @(posedge clk) begin : check_and_predict
    rsp_item_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
      timeout_cfg = TIMEOUT_RST;
      retry_cfg   = RETRY_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_cfg = cfg_data;
          CFG_RETRY:   retry_cfg   = cfg_data[7:0];
          default:     ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none,", $time,
                   " got kind=%0d id=%h dest=%h last=%0d",
                   rsp.kind, rsp.out_id, rsp.out_dest, rsp.last);
        end else begin
          want = expected_results.pop_front();
          if (rsp.kind !== want.kind || rsp.out_id !== want.out_id ||
              rsp.out_dest !== want.out_dest || rsp.last !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch: expected kind=%0d id=%h dest=%h last=%0d,",
                     $time, want.kind, want.out_id, want.out_dest, want.last,
                     " got kind=%0d id=%h dest=%h last=%0d",
                     rsp.kind, rsp.out_id, rsp.out_dest, rsp.last);
          end
        end
      end
      if (req_valid && req_ready) predict_request(req);
    end
    mismatch_count <= mismatches;
    results_owed   <= expected_results.size();
  end

endmodule

// ----- tb/tb_retransmit_timeout_table.sv -----
`timescale 1ns / 1ps

module tb_retransmit_timeout_table;
  import rtt_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          QUIET_LIMIT = 3000;  // cycles with no item moving
  localparam int          HOLD_AT     = 150;   // result count at which the sink backs off
  localparam int          HOLD_CYCLES = 300;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_item_t             req       = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_item_t             rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          mismatch_count;
  int          results_owed;
  int          idle_max   = 12;
  logic [31:0] wall_clock = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  retransmit_timeout_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rtt_result_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  function automatic req_item_t make_request(logic [1:0] op, logic [31:0] id,
                                             logic [15:0] dest, logic [31:0] now);
    req_item_t r;
    r.op          = op;
    r.msg_id      = id;
    r.dest_handle = dest;
    r.now_time    = now;
    return r;
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_request(input req_item_t item);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Both registers, back to back; upper byte of the retry write is junk
  task automatic write_config(input logic [15:0] tmo, input logic [7:0] retries);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= CFG_RETRY;
    cfg_data  <= {8'($urandom), retries};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly ids from a small pool so adds, acks, nacks and scans meet the
  // same entries; time creeps forward by up to about half a timeout per item
  task automatic random_phase(input int count, input int unsigned tmo);
    req_item_t   item;
    logic [31:0] id_base;
    int unsigned span;
    int          roll;
    id_base = $urandom;
    span    = (tmo >> 1) + 1;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      item.op = OP_ADD;
      else if (roll < 55) item.op = OP_ACK;
      else if (roll < 70) item.op = OP_NACK;
      else                item.op = OP_SCAN;
      wall_clock       = wall_clock + $urandom_range(0, span);
      item.msg_id      = id_base + $urandom_range(0, 23);
      item.dest_handle = 16'($urandom);
      item.now_time    = wall_clock;
      // occasional stray id and time
      if ($urandom_range(0, 9) == 0) begin
        item.msg_id   = $urandom;
        item.now_time = $urandom;
      end
      send_request(item);
    end
  endtask

  // Result sink: random stalls, one long back-off to fill the block up
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = (taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, idle_max);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog on cycles where no item moves on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned tmo_pick;
    logic [7:0]  retry_pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings (timeout 2, three resends)
    send_request(make_request(OP_ADD, 32'h0, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_ADD, 32'hFFFF_FFFF, 16'h0, 32'h0));
    // same id again overwrites in place
    send_request(make_request(OP_ADD, 32'h0, 16'h1234, 32'hFFFF_FFFE));
    send_request(make_request(OP_NACK, 32'h0, 16'($urandom), $urandom));
    send_request(make_request(OP_NACK, 32'h5, 16'($urandom), $urandom));
    send_request(make_request(OP_ACK, 32'hFFFF_FFFF, 16'($urandom), $urandom));
    send_request(make_request(OP_ACK, 32'hFFFF_FFFF, 16'($urandom), $urandom));
    // age equal to timeout is not expired; later scans wrap past zero
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd0));
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd1));
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd4));
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd7));
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd10));
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd10));
    // fill every slot, then overflow, overwrite while full, resend all
    for (int k = 0; k < DEPTH; k++)
      send_request(make_request(OP_ADD, 32'hA5A5_0000 + k, 16'(k * 4369), 32'd100));
    send_request(make_request(OP_ADD, 32'hA5A5_0010, 16'h5A5A, 32'd120));
    send_request(make_request(OP_ADD, 32'hA5A5_0003, 16'hFFFF, 32'd150));
    send_request(make_request(OP_NACK, 32'hA5A5_0003, 16'($urandom), $urandom));
    send_request(make_request(OP_SCAN, $urandom, 16'($urandom), 32'd200));

    wall_clock = 32'd300;
    random_phase(100, TIMEOUT_RST);
    drain;

    // zero timeout, no resends, no idling on either side
    idle_max = 0;
    write_config(16'd0, 8'd0);
    random_phase(80, 0);
    drain;

    // largest timeout and retry limit, time wrapping
    idle_max   = 12;
    wall_clock = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
    write_config(16'hFFFF, 8'hFF);
    random_phase(80, 16'hFFFF);
    drain;

    tmo_pick   = $urandom_range(1, 20);
    retry_pick = 8'($urandom_range(1, 6));
    wall_clock = $urandom;
    write_config(16'(tmo_pick), retry_pick);
    random_phase(100, tmo_pick);
    drain;

    write_config(16'd7, 8'd2);
    random_phase(90, 7);
    drain;

    // settle before the final check; drain has already seen the last result
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- retransmit_timeout_table.f -----
rtl/rtt_pkg.sv
rtl/rtt_cell.sv
rtl/retransmit_timeout_table.sv
tb/rtt_result_checker.sv
tb/tb_retransmit_timeout_table.sv
